@@ hdl/oba_pkg.sv @@
// Package: shared types, constants and state encoding for the OHLCV bar aggregator.
package oba_pkg;

    localparam int unsigned DIV_STEPS = 48;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [10:0] MAX_WINDOW = 11'd1024;
    localparam logic [10:0] HELD_MAX   = 11'h7FF;

    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [62:0] M63 = 63'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] REG_TICK_MODE   = 2'd0;
    localparam logic [1:0] REG_BAR_LEN     = 2'd1;
    localparam logic [1:0] REG_MERGE_COUNT = 2'd2;

    localparam logic [31:0] RST_BAR_LEN = 32'd60000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [47:0] time_ms;
        logic [31:0] in_open;
        logic [31:0] in_high;
        logic [31:0] in_low;
        logic [31:0] in_last;
        logic [31:0] in_volume;
        logic [62:0] in_turnover;
    } item_t;

    typedef struct packed {
        logic [47:0] bar_start_ms;
        logic [31:0] bar_open;
        logic [31:0] bar_high;
        logic [31:0] bar_low;
        logic [31:0] bar_close;
        logic [47:0] bar_volume;
        logic [62:0] bar_turnover;
    } bar_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic div_step;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic ignore;
        logic need_div;
        logic emits;
        logic out_full;
        logic div_last;
    } status_t;

endpackage

@@ hdl/oba_channels.sv @@
// Interfaces: input item channel and finished bar channel.
interface oba_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [47:0] time_ms;
    logic [31:0] in_open;
    logic [31:0] in_high;
    logic [31:0] in_low;
    logic [31:0] in_last;
    logic [31:0] in_volume;
    logic [62:0] in_turnover;

    modport source (
        output valid, req_type, time_ms, in_open, in_high, in_low, in_last,
               in_volume, in_turnover,
        input  ready
    );
    modport sink (
        input  valid, req_type, time_ms, in_open, in_high, in_low, in_last,
               in_volume, in_turnover,
        output ready
    );
endinterface

interface oba_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] bar_start_ms;
    logic [31:0] bar_open;
    logic [31:0] bar_high;
    logic [31:0] bar_low;
    logic [31:0] bar_close;
    logic [47:0] bar_volume;
    logic [62:0] bar_turnover;

    modport source (
        output valid, bar_start_ms, bar_open, bar_high, bar_low, bar_close,
               bar_volume, bar_turnover,
        input  ready
    );
    modport sink (
        input  valid, bar_start_ms, bar_open, bar_high, bar_low, bar_close,
               bar_volume, bar_turnover,
        output ready
    );
endinterface

@@ hdl/oba_ctrl.sv @@
// Controller: sequences capture, product, interval division and bar update.
module oba_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  oba_pkg::status_t st,
    output oba_pkg::cmd_t    cmd
);
    import oba_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   apply_ok;

    assign apply_ok = !(st.emits && st.out_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (st.ignore)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.need_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_DIV:
            begin
                if (st.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (apply_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready   = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_APPLY:
            begin
                cmd.apply = apply_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_capture_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_CALC)
        else $error("capture did not advance to calc");

    a_apply_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> state_reg == ST_IDLE)
        else $error("apply did not return to idle");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.calc, cmd.div_step, cmd.apply}))
        else $error("more than one command at once");

endmodule

@@ hdl/oba_datapath.sv @@
// Datapath: config registers, bar accumulators, product, remainder divider, output register.
module oba_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_idx,
    input  logic [31:0]      cfg_data,
    input  oba_pkg::item_t   item,
    input  logic             result_ready,
    input  oba_pkg::cmd_t    cmd,
    output oba_pkg::status_t st,
    output logic             result_valid,
    output oba_pkg::bar_t    result_data
);
    import oba_pkg::*;

    logic        tick_mode_reg;
    logic [31:0] interval_reg;
    logic [10:0] merge_count_reg;

    item_t       item_reg;
    logic [62:0] prod_sat_reg;
    logic [31:0] rem_reg;
    logic [47:0] div_shift_reg;
    logic [CNT_W-1:0] div_cnt_reg;

    logic        have_bar_reg;
    logic [10:0] bars_held_reg;
    bar_t        acc_reg;
    bar_t        acc_next;

    logic        result_valid_reg;
    bar_t        result_data_reg;

    logic [10:0] win;
    logic [48:0] bound;
    logic        late;
    logic        is_tick;
    logic        tick_open;
    logic        first;
    logic [10:0] held_inc;
    logic [63:0] prod;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic [47:0] vol_base;
    logic [48:0] vol_sum;
    logic [62:0] turn_base;
    logic [62:0] turn_add;
    logic [63:0] turn_sum;
    logic        load_out;

    assign win       = (merge_count_reg > MAX_WINDOW) ? MAX_WINDOW : merge_count_reg;
    assign bound     = {1'b0, acc_reg.bar_start_ms} + {17'b0, interval_reg};
    assign late      = {1'b0, item_reg.time_ms} >= bound;
    assign is_tick   = !item_reg.req_type;
    assign tick_open = is_tick && (!have_bar_reg || late);
    assign first     = bars_held_reg == 11'd0;
    assign held_inc  = (bars_held_reg == HELD_MAX) ? bars_held_reg : bars_held_reg + 11'd1;

    assign st.ignore   = is_tick ? !tick_mode_reg : (tick_mode_reg || win == 11'd0);
    assign st.need_div = tick_open && (interval_reg != 32'd0);
    assign st.emits    = is_tick ? (have_bar_reg && late) : (held_inc >= win);
    assign st.out_full = result_valid_reg && !result_ready;
    assign st.div_last = div_cnt_reg == CNT_W'(DIV_STEPS - 1);

    assign prod    = {32'b0, item_reg.in_last} * {32'b0, item_reg.in_volume};
    assign rem_sh  = {rem_reg, div_shift_reg[47]};
    assign rem_sub = rem_sh - {1'b0, interval_reg};

    assign vol_base  = (!is_tick && first) ? 48'd0 : acc_reg.bar_volume;
    assign vol_sum   = {1'b0, vol_base} + {17'b0, item_reg.in_volume};
    assign turn_base = (!is_tick && first) ? 63'd0 : acc_reg.bar_turnover;
    assign turn_add  = is_tick ? prod_sat_reg : item_reg.in_turnover;
    assign turn_sum  = {1'b0, turn_base} + {1'b0, turn_add};

    always_comb
    begin
        acc_next              = acc_reg;
        acc_next.bar_close    = item_reg.in_last;
        acc_next.bar_volume   = vol_sum[48] ? M48 : vol_sum[47:0];
        acc_next.bar_turnover = turn_sum[63] ? M63 : turn_sum[62:0];
        if (is_tick)
        begin
            if (tick_open)
            begin
                acc_next.bar_start_ms = item_reg.time_ms - {16'b0, rem_reg};
                acc_next.bar_open     = item_reg.in_last;
                acc_next.bar_high     = item_reg.in_last;
                acc_next.bar_low      = item_reg.in_last;
                acc_next.bar_volume   = {16'b0, item_reg.in_volume};
                acc_next.bar_turnover = prod_sat_reg;
            end
            else
            begin
                if (item_reg.in_last > acc_reg.bar_high)
                begin
                    acc_next.bar_high = item_reg.in_last;
                end
                if (item_reg.in_last < acc_reg.bar_low)
                begin
                    acc_next.bar_low = item_reg.in_last;
                end
            end
        end
        else if (first)
        begin
            acc_next.bar_start_ms = item_reg.time_ms;
            acc_next.bar_open     = item_reg.in_open;
            acc_next.bar_high     = item_reg.in_high;
            acc_next.bar_low      = item_reg.in_low;
        end
        else
        begin
            if (item_reg.in_high > acc_reg.bar_high)
            begin
                acc_next.bar_high = item_reg.in_high;
            end
            if (item_reg.in_low < acc_reg.bar_low)
            begin
                acc_next.bar_low = item_reg.in_low;
            end
        end
    end

    assign load_out = cmd.apply && st.emits;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.calc)
        begin
            prod_sat_reg  <= prod[63] ? M63 : prod[62:0];
            rem_reg       <= 32'd0;
            div_shift_reg <= item_reg.time_ms;
        end
        else if (cmd.div_step)
        begin
            rem_reg       <= rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
            div_shift_reg <= {div_shift_reg[46:0], 1'b0};
        end
        if (load_out)
        begin
            // tick bars go out as held, bar-mode windows include this beat
            result_data_reg <= is_tick ? acc_reg : acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_mode_reg    <= 1'b1;
            interval_reg     <= RST_BAR_LEN;
            merge_count_reg  <= 11'd0;
            have_bar_reg     <= 1'b0;
            bars_held_reg    <= 11'd0;
            acc_reg          <= '0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.calc)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            end

            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            if (cmd.apply)
            begin
                acc_reg <= acc_next;
                if (is_tick)
                begin
                    have_bar_reg <= 1'b1;
                end
                else
                begin
                    bars_held_reg <= st.emits ? 11'd0 : held_inc;
                end
            end

            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_TICK_MODE:
                    begin
                        tick_mode_reg <= cfg_data[0];
                        have_bar_reg  <= 1'b0;
                        bars_held_reg <= 11'd0;
                    end
                    REG_BAR_LEN:
                    begin
                        interval_reg <= cfg_data;
                    end
                    REG_MERGE_COUNT:
                    begin
                        merge_count_reg <= cfg_data[10:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !(result_valid_reg && !result_ready))
        else $error("finished bar overwritten while stalled");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> div_cnt_reg < CNT_W'(DIV_STEPS))
        else $error("divider ran past its last step");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bars_held_reg < MAX_WINDOW)
        else $error("bar count reached window limit without emit");

    a_tick_opens: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && is_tick && !cfg_we |=> have_bar_reg)
        else $error("tick applied but no bar held");

endmodule

@@ hdl/ohlcv_bar_aggregator.sv @@
// Top level: OHLCV bar aggregator with item, result and config ports.
//
// Usage: item carries either a trade tick (req_type 0) or a finished bar
// (req_type 1); result carries finished OHLCV bars. Both are valid/ready
// channels, a beat moves when valid and ready are high at a clock edge.
// cfg_we/cfg_idx/cfg_data write the tick mode (0), the bar length in ms (1)
// and the bars per merge (2); write only while the block is idle.
// Items are taken one at a time: item ready is low through the calc step,
// the update step and, when a tick opens a bar under a nonzero interval, the
// division that aligns the bar start with a one-bit-per-cycle remainder
// divider over the 48-bit timestamp. Items of the wrong kind end after the
// calc step. A finished bar is loaded into the output register on update.
// A finished bar sits in the output register while result is stalled; the
// next item is still taken, and an item that would finish another bar holds
// in its update step, with item ready low, until the held bar has gone out.
// Reset clears the held bar, the window count and the output valid, and
// restores tick mode with a 60000 ms interval and bar mode disabled.
module ohlcv_bar_aggregator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_data,
    oba_in_if.sink      item,
    oba_out_if.source   result
);
    import oba_pkg::*;

    cmd_t    cmd;
    status_t st;
    item_t   item_data;
    bar_t    bar_data;

    assign item_data.req_type    = item.req_type;
    assign item_data.time_ms     = item.time_ms;
    assign item_data.in_open     = item.in_open;
    assign item_data.in_high     = item.in_high;
    assign item_data.in_low      = item.in_low;
    assign item_data.in_last     = item.in_last;
    assign item_data.in_volume   = item.in_volume;
    assign item_data.in_turnover = item.in_turnover;

    oba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .st         (st),
        .cmd        (cmd)
    );

    oba_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .item         (item_data),
        .result_ready (result.ready),
        .cmd          (cmd),
        .st           (st),
        .result_valid (result.valid),
        .result_data  (bar_data)
    );

    assign result.bar_start_ms = bar_data.bar_start_ms;
    assign result.bar_open     = bar_data.bar_open;
    assign result.bar_high     = bar_data.bar_high;
    assign result.bar_low      = bar_data.bar_low;
    assign result.bar_close    = bar_data.bar_close;
    assign result.bar_volume   = bar_data.bar_volume;
    assign result.bar_turnover = bar_data.bar_turnover;

endmodule

@@ bench/tb.sv @@
// Testbench for ohlcv_bar_aggregator: random and directed items checked against a bar predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oba_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 360;
    localparam int unsigned DRAIN_CYCLES    = 64;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT     = 12_000_000;
    localparam int unsigned WIDE_BARS       = 1030;
    localparam int unsigned VOLUME_TICKS    = 30;

    localparam logic [1:0]  REG_UNUSED = 2'd3;
    localparam logic [31:0] MINUTE_MS  = 32'd60000;
    localparam logic [31:0] DAY_MS     = 32'd86400000;
    localparam logic [31:0] WEEK_MS    = 32'd604800000;
    localparam logic [31:0] MONTH_MS   = 32'd2592000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    oba_in_if  item_ch ();
    oba_out_if bar_ch ();

    ohlcv_bar_aggregator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (bar_ch)
    );

    always #2 clk = ~clk;

    // predictor state
    logic        mode_ticks;
    logic [31:0] bar_interval;
    logic [10:0] merge_window;
    logic        held_valid;
    logic [47:0] held_start;
    logic [31:0] held_open;
    logic [31:0] held_high;
    logic [31:0] held_low;
    logic [31:0] held_close;
    logic [47:0] held_volume;
    logic [62:0] held_turnover;
    logic [10:0] held_count;

    item_t pending_items[$];
    bar_t  expected_bars[$];
    item_t fresh_item;
    item_t offered_item;

    logic        steady = 1'b0;
    logic        hold_off_req = 1'b0;
    logic        hold_off_armed;
    int unsigned hold_off_left;
    int unsigned send_gap;
    int unsigned take_gap;
    int unsigned cycle_count = 0;
    int unsigned items_taken = 0;
    int unsigned input_stalls = 0;
    int unsigned bars_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cfg_writes = 0;
    int unsigned random_items = 0;
    int unsigned phase_no;

    function automatic void reset_model();
        mode_ticks    = 1'b1;
        bar_interval  = RST_BAR_LEN;
        merge_window  = '0;
        held_valid    = 1'b0;
        held_start    = '0;
        held_open     = '0;
        held_high     = '0;
        held_low      = '0;
        held_close    = '0;
        held_volume   = '0;
        held_turnover = '0;
        held_count    = '0;
    endfunction

    function automatic void apply_cfg(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_TICK_MODE:
            begin
                mode_ticks = data[0];
                held_valid = 1'b0;
                held_count = '0;
            end
            REG_BAR_LEN: bar_interval = data;
            REG_MERGE_COUNT: merge_window = data[10:0];
            default: ;
        endcase
    endfunction

    function automatic logic [62:0] capped_product(input logic [31:0] px, input logic [31:0] qty);
        logic [63:0] p;
        p = px * qty;
        return p[63] ? M63 : p[62:0];
    endfunction

    function automatic logic [47:0] add_volume(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = a + b;
        return s[48] ? M48 : s[47:0];
    endfunction

    function automatic logic [62:0] add_turnover(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = a + b;
        return s[63] ? M63 : s[62:0];
    endfunction

    function automatic void bank_held_bar();
        bar_t finished;
        finished.bar_start_ms = held_start;
        finished.bar_open     = held_open;
        finished.bar_high     = held_high;
        finished.bar_low      = held_low;
        finished.bar_close    = held_close;
        finished.bar_volume   = held_volume;
        finished.bar_turnover = held_turnover;
        expected_bars = {expected_bars, finished};
    endfunction

    function automatic void open_tick_bar(input logic [47:0] t, input logic [31:0] px,
                                          input logic [31:0] qty);
        held_start    = (bar_interval == 0) ? t : (t / bar_interval) * bar_interval;
        held_open     = px;
        held_high     = px;
        held_low      = px;
        held_close    = px;
        held_volume   = {16'd0, qty};
        held_turnover = capped_product(px, qty);
        held_valid    = 1'b1;
    endfunction

    function automatic void advance_bar_model(input item_t it);
        logic [10:0] win;
        if (it.req_type == 1'b0) begin
            if (!mode_ticks)
                return;
            if (!held_valid) begin
                open_tick_bar(it.time_ms, it.in_last, it.in_volume);
                return;
            end
            if ({16'd0, it.time_ms} >= {16'd0, held_start} + {32'd0, bar_interval}) begin
                bank_held_bar();
                open_tick_bar(it.time_ms, it.in_last, it.in_volume);
                return;
            end
            if (it.in_last > held_high)
                held_high = it.in_last;
            if (it.in_last < held_low)
                held_low = it.in_last;
            held_close    = it.in_last;
            held_volume   = add_volume(held_volume, it.in_volume);
            held_turnover = add_turnover(held_turnover, capped_product(it.in_last, it.in_volume));
            return;
        end
        win = (merge_window > MAX_WINDOW) ? MAX_WINDOW : merge_window;
        if (mode_ticks || win == 0)
            return;
        if (held_count == 0) begin
            held_start    = it.time_ms;
            held_open     = it.in_open;
            held_high     = it.in_high;
            held_low      = it.in_low;
            held_volume   = '0;
            held_turnover = '0;
        end
        else begin
            if (it.in_high > held_high)
                held_high = it.in_high;
            if (it.in_low < held_low)
                held_low = it.in_low;
        end
        held_close    = it.in_last;
        held_volume   = add_volume(held_volume, it.in_volume);
        held_turnover = add_turnover(held_turnover, it.in_turnover);
        if (held_count != HELD_MAX)
            held_count = held_count + 1'b1;
        if (held_count >= win) begin
            bank_held_bar();
            held_count = '0;
        end
    endfunction

    function automatic void check_field(input string label, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", label, want, got);
        end
    endfunction

    function automatic void check_bar();
        bar_t want;
        if (expected_bars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected bar with start %h", bar_ch.bar_start_ms);
            return;
        end
        want = expected_bars.pop_front();
        bars_checked++;
        check_field("bar_start_ms", want.bar_start_ms, bar_ch.bar_start_ms);
        check_field("bar_open", want.bar_open, bar_ch.bar_open);
        check_field("bar_high", want.bar_high, bar_ch.bar_high);
        check_field("bar_low", want.bar_low, bar_ch.bar_low);
        check_field("bar_close", want.bar_close, bar_ch.bar_close);
        check_field("bar_volume", want.bar_volume, bar_ch.bar_volume);
        check_field("bar_turnover", want.bar_turnover, bar_ch.bar_turnover);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rnd48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    function automatic logic [31:0] rnd_price();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(1, 100);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rnd_qty();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return $urandom_range(1, 1000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [62:0] rnd_turnover();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return M63;
            2, 3: return $urandom_range(1, 100000);
            default: return r[62:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return $urandom_range(2, 50);
            3: return 32'd1000;
            4: return MINUTE_MS;
            5: return DAY_MS;
            6: return WEEK_MS;
            7: return MONTH_MS;
            8: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [10:0] pick_window();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return 11'd1;
            8: return $urandom_range(9, 40);
            9: return $urandom_range(2, 4);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    function automatic logic [63:0] tick_step(input logic [31:0] iv);
        case ($urandom_range(0, 11))
            0, 1: return '0;
            2, 3, 4: return $urandom_range(1, 40);
            5, 6: return (iv == 0) ? 64'd1 : {32'd0, $urandom()} % ({32'd0, iv} / 4 + 1);
            7: return (iv == 0) ? 64'd0 : {32'd0, iv} - 1;
            8: return {32'd0, iv};
            9: return {32'd0, iv} + $urandom_range(0, 5000);
            10: return {32'd0, iv} * $urandom_range(2, 4);
            default: return {32'd0, $urandom()};
        endcase
    endfunction

    function automatic void push_tick(input logic [47:0] t, input logic [31:0] px,
                                      input logic [31:0] qty);
        item_t it;
        it.req_type    = 1'b0;
        it.time_ms     = t;
        it.in_open     = $urandom();
        it.in_high     = $urandom();
        it.in_low      = $urandom();
        it.in_last     = px;
        it.in_volume   = qty;
        it.in_turnover = rnd_turnover();
        pending_items = {pending_items, it};
    endfunction

    function automatic void push_bar(input logic [47:0] t, input logic [31:0] o,
                                     input logic [31:0] h, input logic [31:0] l,
                                     input logic [31:0] c, input logic [31:0] v,
                                     input logic [62:0] tv);
        item_t it;
        it.req_type    = 1'b1;
        it.time_ms     = t;
        it.in_open     = o;
        it.in_high     = h;
        it.in_low      = l;
        it.in_last     = c;
        it.in_volume   = v;
        it.in_turnover = tv;
        pending_items = {pending_items, it};
    endfunction

    function automatic void push_random_bar(input logic [47:0] t);
        push_bar(t, rnd_price(), rnd_price(), rnd_price(), rnd_price(), rnd_qty(),
                 rnd_turnover());
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_cfg(idx, data);
        cfg_writes++;
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || item_ch.valid || expected_bars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        bit          bars;
        int unsigned n;
        int unsigned k;
        logic [63:0] clock_ms;
        bars = ($urandom_range(0, 9) < 4);
        if (mode_ticks == bars || $urandom_range(0, 1) == 0)
            cfg_write(REG_TICK_MODE, {31'd0, !bars});
        if ($urandom_range(0, 9) < 6)
            cfg_write(REG_BAR_LEN, pick_interval());
        if (bars && $urandom_range(0, 9) < 7)
            cfg_write(REG_MERGE_COUNT, {21'd0, pick_window()});
        steady <= ($urandom_range(0, 3) == 0);
        n = $urandom_range(10, 60);
        clock_ms = ($urandom_range(0, 4) == 0) ? {16'd0, rnd48()} : {32'd0, $urandom()};
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                if (bars)
                    push_tick(rnd48(), rnd_price(), rnd_qty());
                else
                    push_random_bar(rnd48());
            end
            else begin
                if ($urandom_range(0, 15) == 0)
                    clock_ms = (clock_ms > 100000) ? clock_ms - $urandom_range(1, 100000) : 0;
                else
                    clock_ms = clock_ms + (bars ? {32'd0, $urandom_range(0, 100000)}
                                                : tick_step(bar_interval));
                if (clock_ms > {16'd0, M48})
                    clock_ms = ($urandom_range(0, 1) == 0) ? {16'd0, M48}
                                                           : {32'd0, $urandom_range(0, 100000)};
                if (bars)
                    push_random_bar(clock_ms[47:0]);
                else
                    push_tick(clock_ms[47:0], rnd_price(), rnd_qty());
                if (!bars || merge_window != 0)
                    random_items++;
            end
        end
    endtask

    // every tick after the first closes a bar while the result side is held off
    task automatic hold_off_phase();
        int unsigned k;
        logic [47:0] t;
        cfg_write(REG_TICK_MODE, 32'd1);
        cfg_write(REG_BAR_LEN, 32'd0);
        steady       <= 1'b1;
        hold_off_req <= 1'b1;
        t = $urandom();
        for (k = 0; k < 40; k++) begin
            t = t + $urandom_range(0, 3);
            push_tick(t, rnd_price(), rnd_qty());
            random_items++;
        end
        while (pending_items.size() != 0)
            @(posedge clk);
        hold_off_req <= 1'b0;
        steady       <= 1'b0;
    endtask

    task automatic wide_window_phase();
        int unsigned k;
        cfg_write(REG_TICK_MODE, 32'd0);
        cfg_write(REG_MERGE_COUNT, {21'd0, HELD_MAX});
        for (k = 0; k < WIDE_BARS; k++)
            push_random_bar(48'(k) * MINUTE_MS);
    endtask

    task automatic volume_phase();
        int unsigned k;
        logic [47:0] t;
        cfg_write(REG_TICK_MODE, 32'd1);
        cfg_write(REG_BAR_LEN, 32'hFFFF_FFFF);
        steady <= 1'b1;
        t = {16'd0, $urandom()};
        for (k = 0; k < VOLUME_TICKS; k++)
            push_tick(t, rnd_price(), '1);
        push_tick(t + 48'h1_FFFF_FFFE, rnd_price(), rnd_qty());
    endtask

    // sender
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
            send_gap      <= 0;
        end
        else begin
            if (item_ch.valid && item_ch.ready) begin
                advance_bar_model(offered_item);
                items_taken++;
            end
            if (item_ch.valid && !item_ch.ready)
                input_stalls++;
            if (!item_ch.valid || item_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap      <= send_gap - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    fresh_item   = pending_items.pop_front();
                    offered_item = fresh_item;
                    item_ch.valid       <= 1'b1;
                    item_ch.req_type    <= fresh_item.req_type;
                    item_ch.time_ms     <= fresh_item.time_ms;
                    item_ch.in_open     <= fresh_item.in_open;
                    item_ch.in_high     <= fresh_item.in_high;
                    item_ch.in_low      <= fresh_item.in_low;
                    item_ch.in_last     <= fresh_item.in_last;
                    item_ch.in_volume   <= fresh_item.in_volume;
                    item_ch.in_turnover <= fresh_item.in_turnover;
                    send_gap            <= pick_gap();
                end
                else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_off_armed <= 1'b0;
            hold_off_left  <= 0;
        end
        else begin
            hold_off_armed <= hold_off_req;
            if (hold_off_req && !hold_off_armed)
                hold_off_left <= HOLD_OFF_CYCLES;
            else if (hold_off_left != 0)
                hold_off_left <= hold_off_left - 1;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bar_ch.ready <= 1'b0;
            take_gap     <= 0;
        end
        else begin
            if (bar_ch.valid && bar_ch.ready)
                check_bar();
            if (hold_off_left != 0) begin
                bar_ch.ready <= 1'b0;
            end
            else if (take_gap != 0) begin
                take_gap     <= take_gap - 1;
                bar_ch.ready <= 1'b0;
            end
            else begin
                bar_ch.ready <= 1'b1;
                if (bar_ch.valid && bar_ch.ready)
                    take_gap <= pick_gap();
                else if (!steady && $urandom_range(0, 31) == 0)
                    take_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = REG_TICK_MODE;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.req_type    = 1'b0;
        item_ch.time_ms     = '0;
        item_ch.in_open     = '0;
        item_ch.in_high     = '0;
        item_ch.in_low      = '0;
        item_ch.in_last     = '0;
        item_ch.in_volume   = '0;
        item_ch.in_turnover = '0;
        bar_ch.ready        = 1'b0;
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(REG_UNUSED, $urandom());
        push_tick(48'd125000, 32'd100, 32'd5);
        push_tick(48'd130000, '1, '1);
        push_tick(48'd119999, '0, '0);
        push_random_bar(48'd130500);
        push_tick(48'd179999, 32'd7, 32'd1);
        push_tick(48'd180000, 32'd9, 32'd2);
        push_tick(M48, 32'd50, 32'd3);
        push_tick(M48, 32'd51, 32'd4);
        settle();
        cfg_write(REG_BAR_LEN, 32'd0);
        push_tick(48'd5, 32'd1, 32'd1);
        push_tick(M48, 32'd2, 32'd2);
        push_tick(M48, 32'd3, 32'd3);
        settle();
        cfg_write(REG_TICK_MODE, 32'd0);
        cfg_write(REG_MERGE_COUNT, 32'd3);
        push_bar(48'd10, '0, '1, '0, '1, '1, M63);
        push_tick(48'd15, rnd_price(), rnd_qty());
        push_bar(48'd20, '1, '0, '1, '0, '1, M63);
        push_bar(M48, 32'd5, 32'd6, 32'd1, 32'd3, '0, '0);
        settle();
        cfg_write(REG_MERGE_COUNT, 32'd4);
        push_random_bar(48'd1000);
        push_random_bar(48'd2000);
        push_random_bar(48'd3000);
        settle();
        cfg_write(REG_MERGE_COUNT, 32'd1);
        push_random_bar(48'd4000);
        settle();
        cfg_write(REG_MERGE_COUNT, 32'd0);
        push_random_bar(48'd5000);

        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            if (phase_no == 3)
                hold_off_phase();
            else
                random_phase();
            phase_no++;
        end
        settle();
        wide_window_phase();
        settle();
        volume_phase();
        settle();

        $display("covered %0d items over %0d phases with %0d register writes",
                 items_taken, phase_no, cfg_writes);
        $display("compared %0d bars, %0d cycles of input backpressure, %0d mismatches",
                 bars_checked, input_stalls, mismatches);
        if (mismatches == 0 && expected_bars.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
